// ----- sv/csl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_pkg: shared types and constants for the C-subset lexer
// Token codes, scanner state codes, character classes and the token record.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int MAX_LEXEME_DEF    = 255;
  localparam int POSITION_BITS_DEF = 20;
  localparam int VALUE_BITS_DEF    = 32;
  localparam int LC_BITS           = 21;

  // token types
  localparam logic [5:0] T_EOF   = 6'd0;
  localparam logic [5:0] T_IDENT = 6'd1;
  localparam logic [5:0] T_INT   = 6'd2;
  localparam logic [5:0] T_FLOAT = 6'd3;
  localparam logic [5:0] T_CHARL = 6'd4;
  localparam logic [5:0] T_STRL  = 6'd5;
  localparam logic [5:0] T_KW0   = 6'd6;
  localparam logic [5:0] T_OP2   = 6'd22;
  localparam logic [5:0] T_OP1   = 6'd28;
  localparam logic [5:0] T_SLASH = 6'd31;
  localparam logic [5:0] T_DELIM = 6'd37;
  localparam logic [5:0] T_DOT   = 6'd45;

  // scanner states
  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SLASH  = 4'd1;
  localparam logic [3:0] ST_LINE   = 4'd2;
  localparam logic [3:0] ST_BLOCK  = 4'd3;
  localparam logic [3:0] ST_BSTAR  = 4'd4;
  localparam logic [3:0] ST_IDENT  = 4'd5;
  localparam logic [3:0] ST_NUM    = 4'd6;
  localparam logic [3:0] ST_NUMDOT = 4'd7;
  localparam logic [3:0] ST_FRAC   = 4'd8;
  localparam logic [3:0] ST_OP     = 4'd9;
  localparam logic [3:0] ST_CHAR   = 4'd10;
  localparam logic [3:0] ST_STR    = 4'd11;

  // one token as it leaves the lexer, before width formatting
  typedef struct packed {
    logic [5:0]  ttype;
    logic [20:0] line;
    logic [20:0] column;
    logic [31:0] offset;
    logic [7:0]  length;
    logic [63:0] value;
    logic        sat;
  } token_t;

  // up to three tokens caused by one input item
  typedef struct packed {
    logic [1:0] count;
    token_t     t0;
    token_t     t1;
    token_t     t2;
  } group_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [5:0] op1_type(input logic [7:0] c);
    logic [5:0] t;
    t = 6'd0;
    case (c)
      "+": t = T_OP1;
      "-": t = T_OP1 + 6'd1;
      "*": t = T_OP1 + 6'd2;
      "/": t = T_OP1 + 6'd3;
      "%": t = T_OP1 + 6'd4;
      "<": t = T_OP1 + 6'd5;
      ">": t = T_OP1 + 6'd6;
      "!": t = T_OP1 + 6'd7;
      "=": t = T_OP1 + 6'd8;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  function automatic logic [5:0] delim_type(input logic [7:0] c);
    logic [5:0] t;
    t = 6'd0;
    case (c)
      "(": t = T_DELIM;
      ")": t = T_DELIM + 6'd1;
      "[": t = T_DELIM + 6'd2;
      "]": t = T_DELIM + 6'd3;
      "{": t = T_DELIM + 6'd4;
      "}": t = T_DELIM + 6'd5;
      ";": t = T_DELIM + 6'd6;
      ",": t = T_DELIM + 6'd7;
      ".": t = T_DELIM + 6'd8;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  // two-character operator made of pending p and next c; 0 when none
  function automatic logic [5:0] op2_type(input logic [7:0] p, input logic [7:0] c);
    logic [5:0] t;
    t = 6'd0;
    if (p == "=" && c == "=") t = T_OP2;
    if (p == "!" && c == "=") t = T_OP2 + 6'd1;
    if (p == "<" && c == "=") t = T_OP2 + 6'd2;
    if (p == ">" && c == "=") t = T_OP2 + 6'd3;
    if (p == "&" && c == "&") t = T_OP2 + 6'd4;
    if (p == "|" && c == "|") t = T_OP2 + 6'd5;
    return t;
  endfunction

  // keyword lookup on the right-aligned window
  function automatic logic [5:0] kw_type(input logic [63:0] w, input logic [7:0] len);
    logic [5:0] t;
    t = T_IDENT;
    case (len)
      8'd2: if (w == 64'h6966) t = T_KW0 + 6'd5;
      8'd3: begin
        if (w == 64'h696e74) t = T_KW0;
        if (w == 64'h666f72) t = T_KW0 + 6'd8;
      end
      8'd4: begin
        if (w == 64'h626f6f6c) t = T_KW0 + 6'd2;
        if (w == 64'h63686172) t = T_KW0 + 6'd3;
        if (w == 64'h766f6964) t = T_KW0 + 6'd4;
        if (w == 64'h656c7365) t = T_KW0 + 6'd6;
        if (w == 64'h74727565) t = T_KW0 + 6'd12;
        if (w == 64'h72656164) t = T_KW0 + 6'd15;
      end
      8'd5: begin
        if (w == 64'h666c6f6174) t = T_KW0 + 6'd1;
        if (w == 64'h7768696c65) t = T_KW0 + 6'd7;
        if (w == 64'h627265616b) t = T_KW0 + 6'd10;
        if (w == 64'h66616c7365) t = T_KW0 + 6'd13;
        if (w == 64'h7072696e74) t = T_KW0 + 6'd14;
      end
      8'd6: if (w == 64'h72657475726e) t = T_KW0 + 6'd9;
      8'd8: if (w == 64'h636f6e74696e7565) t = T_KW0 + 6'd11;
      default: t = T_IDENT;
    endcase
    return t;
  endfunction

endpackage

// ----- sv/c_subset_lexer.sv -----
`timescale 1ns / 1ps
// Path: a byte's tokens pass the front end's output register and the token queue before reaching m_axis.
// Throughput: one byte per cycle while the queue has room; output sends one token per
// cycle while m_axis_tready is high, so a byte that yields several tokens sends them in turn,
// absorbed by the four-group token queue between front end and serializer.
// Reset: rst (synchronous) returns to line 1, column 1, offset 0, queue empty.
// ----------------------------------------------------------------------------
// c_subset_lexer: streaming lexer for a small C-like language
// Byte stream in, token stream out; front end scans, back end serializes.
// ----------------------------------------------------------------------------
module c_subset_lexer import csl_pkg::*; #(
  parameter int MAX_LEXEME    = MAX_LEXEME_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // source_byte
  input  logic          s_axis_tuser,   // mode
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // token_type[5:0], token_line[26:6], token_column[47:27],
  // start_offset, lexeme_length, int_value, value_saturated (from low bits up)
  output logic [((6+42+POSITION_BITS+8+VALUE_BITS+1+7)/8)*8-1:0] m_axis_tdata,
  output logic          m_axis_tlast    // last_of_run
);

  localparam int PAYLOAD = 6 + 42 + POSITION_BITS + 8 + VALUE_BITS + 1;
  localparam int TDW     = ((PAYLOAD + 7) / 8) * 8;

  group_t grp;
  logic   grp_valid, grp_ready;
  token_t tok;

  csl_front #(
    .MAX_LEXEME(MAX_LEXEME), .POSITION_BITS(POSITION_BITS), .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_mode(s_axis_tuser), .in_byte(s_axis_tdata),
    .grp_valid(grp_valid), .grp_ready(grp_ready), .grp(grp)
  );

  csl_back #(
    .POSITION_BITS(POSITION_BITS), .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk(clk), .rst(rst),
    .grp_valid(grp_valid), .grp_ready(grp_ready), .grp(grp),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_token(tok), .out_last(m_axis_tlast)
  );

  // pack the token fields
  assign m_axis_tdata = TDW'({tok.sat, tok.value[VALUE_BITS-1:0], tok.length,
                              tok.offset[POSITION_BITS-1:0], tok.column, tok.line,
                              tok.ttype});

  // an offered group stays valid until the queue takes it
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    grp_valid && !grp_ready |=> grp_valid)
    else $error("token group dropped");

  // an EOF token always ends its run
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && tok.ttype == T_EOF |-> m_axis_tlast)
    else $error("EOF not last of run");

  // tokens other than DOT carry a nonzero line
  a_line: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && tok.ttype != T_DOT |-> tok.line != '0)
    else $error("token line zero");

endmodule

// ----- sv/csl_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_front: scanner front end
// Takes one request per cycle while in_ready is high, updates the scan state and
// position counters, and pushes the group of tokens the byte produced into the queue.
// ----------------------------------------------------------------------------
module csl_front import csl_pkg::*; #(
  parameter int MAX_LEXEME    = MAX_LEXEME_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_byte,
  output logic        grp_valid,
  input  logic        grp_ready,
  output group_t      grp
);

  localparam logic [VALUE_BITS-1:0] VMAX = '1;
  localparam logic [7:0] LMAX = 8'(MAX_LEXEME);
  localparam logic [LC_BITS-1:0] LCMAX = '1;

  logic [3:0]               scan_state, scan_state_next;
  logic [7:0]               pending_char, pending_char_next;
  logic [63:0]              keyword_window, keyword_window_next;
  logic [LC_BITS-1:0]       current_line, current_column;
  logic [POSITION_BITS-1:0] current_offset;
  logic [LC_BITS-1:0]       start_line, start_line_next;
  logic [LC_BITS-1:0]       start_column, start_column_next;
  logic [POSITION_BITS-1:0] start_position, start_position_next;
  logic [7:0]               length_count, length_count_next;
  logic [VALUE_BITS-1:0]    value_accumulator, value_accumulator_next;
  logic                     escape_pending, escape_pending_next;
  logic                     len_sat, len_sat_next, val_sat, val_sat_next;
  logic [LC_BITS-1:0]       mark_line, mark_line_next, mark_column, mark_column_next;
  logic [POSITION_BITS-1:0] mark_offset, mark_offset_next;

  logic   fire;
  group_t g;

  assign in_ready = !grp_valid || grp_ready;
  assign fire     = in_valid && in_ready;

  // combinational step of the scanner
  always_comb begin
    token_t tk [3];
    logic [1:0] n;
    logic rescan;
    logic [7:0] c;
    logic [5:0] t;
    logic [VALUE_BITS+3:0] prod;
    logic [VALUE_BITS-1:0] dval;

    c = in_byte;
    n = 2'd0;
    rescan = 1'b0;
    for (int i = 0; i < 3; i++) tk[i] = '0;
    scan_state_next        = scan_state;
    pending_char_next      = pending_char;
    keyword_window_next    = keyword_window;
    start_line_next        = start_line;
    start_column_next      = start_column;
    start_position_next    = start_position;
    length_count_next      = length_count;
    value_accumulator_next = value_accumulator;
    escape_pending_next    = escape_pending;
    len_sat_next           = len_sat;
    val_sat_next           = val_sat;
    mark_line_next         = mark_line;
    mark_column_next       = mark_column;
    mark_offset_next       = mark_offset;
    t = 6'd0;
    dval = VALUE_BITS'(c - "0");
    prod = {4'd0, value_accumulator} * (VALUE_BITS+4)'(10) + (VALUE_BITS+4)'(dval);

    // tokens pending in the current state (flush / terminate)
    if (in_mode || (scan_state != ST_IDLE)) begin
      case (scan_state)
        ST_SLASH: begin
          if (in_mode || (c != "/" && c != "*")) begin
            tk[n] = '{T_SLASH, start_line, start_column, 32'(start_position), 8'd1, 64'd0, 1'b0};
            n = n + 2'd1;
            rescan = 1'b1;
          end else if (c == "/") scan_state_next = ST_LINE;
          else scan_state_next = ST_BLOCK;
        end
        ST_LINE: if (!in_mode && c == "\n") scan_state_next = ST_IDLE;
        ST_BLOCK: if (!in_mode && c == "*") scan_state_next = ST_BSTAR;
        ST_BSTAR: if (!in_mode) begin
          if (c == "/") scan_state_next = ST_IDLE;
          else if (c != "*") scan_state_next = ST_BLOCK;
        end
        ST_IDENT: begin
          if (!in_mode && (is_alpha(c) || is_digit(c))) begin
            if (length_count < LMAX) length_count_next = length_count + 8'd1;
            else len_sat_next = 1'b1;
            keyword_window_next = {keyword_window[55:0], c};
          end else begin
            tk[n] = '{(length_count <= 8'd8) ? kw_type(keyword_window, length_count) : T_IDENT,
                      start_line, start_column, 32'(start_position), length_count, 64'd0,
                      len_sat};
            n = n + 2'd1;
            rescan = 1'b1;
          end
        end
        ST_NUM: begin
          if (!in_mode && is_digit(c)) begin
            if (length_count < LMAX) length_count_next = length_count + 8'd1;
            else len_sat_next = 1'b1;
            if (!val_sat) begin
              if (prod > (VALUE_BITS+4)'(VMAX)) begin
                value_accumulator_next = VMAX;
                val_sat_next = 1'b1;
              end else value_accumulator_next = prod[VALUE_BITS-1:0];
            end
          end else if (!in_mode && c == ".") begin
            scan_state_next  = ST_NUMDOT;
            mark_line_next   = current_line;
            mark_column_next = current_column;
            mark_offset_next = current_offset;
          end else begin
            tk[n] = '{T_INT, start_line, start_column, 32'(start_position), length_count,
                      64'(value_accumulator), len_sat || val_sat};
            n = n + 2'd1;
            rescan = 1'b1;
          end
        end
        ST_NUMDOT: begin
          if (!in_mode && is_digit(c)) begin
            if (length_count <= LMAX - 8'd2) length_count_next = length_count + 8'd2;
            else begin
              length_count_next = LMAX;
              len_sat_next = 1'b1;
            end
            scan_state_next = ST_FRAC;
          end else begin
            tk[n] = '{T_INT, start_line, start_column, 32'(start_position), length_count,
                      64'(value_accumulator), len_sat || val_sat};
            n = n + 2'd1;
            tk[n] = '{T_DOT, mark_line, mark_column, 32'(mark_offset), 8'd1, 64'd0, 1'b0};
            n = n + 2'd1;
            rescan = 1'b1;
          end
        end
        ST_FRAC: begin
          if (!in_mode && is_digit(c)) begin
            if (length_count < LMAX) length_count_next = length_count + 8'd1;
            else len_sat_next = 1'b1;
          end else begin
            tk[n] = '{T_FLOAT, start_line, start_column, 32'(start_position), length_count,
                      64'd0, len_sat};
            n = n + 2'd1;
            rescan = 1'b1;
          end
        end
        ST_OP: begin
          t = op2_type(pending_char, c);
          if (!in_mode && t != 6'd0) begin
            tk[n] = '{t, start_line, start_column, 32'(start_position), 8'd2, 64'd0, 1'b0};
            n = n + 2'd1;
            scan_state_next = ST_IDLE;
          end else begin
            t = op1_type(pending_char);
            if (t != 6'd0) begin
              tk[n] = '{t, start_line, start_column, 32'(start_position), 8'd1, 64'd0, 1'b0};
              n = n + 2'd1;
            end
            rescan = 1'b1;
          end
        end
        ST_CHAR, ST_STR: if (!in_mode) begin
          if (escape_pending) begin
            escape_pending_next = 1'b0;
            if (length_count < LMAX) length_count_next = length_count + 8'd1;
            else len_sat_next = 1'b1;
          end else if (c == "\n" || (scan_state == ST_STR && (c == ")" || c == ";"))) begin
            rescan = 1'b1;
          end else if ((scan_state == ST_CHAR && c == "'") ||
                       (scan_state == ST_STR && c == "\"")) begin
            tk[n] = '{(scan_state == ST_CHAR) ? T_CHARL : T_STRL, start_line, start_column,
                      32'(start_position),
                      (length_count < LMAX) ? length_count + 8'd1 : length_count,
                      64'd0, len_sat || (length_count >= LMAX)};
            n = n + 2'd1;
            scan_state_next = ST_IDLE;
          end else begin
            if (c == "\\") escape_pending_next = 1'b1;
            if (length_count < LMAX) length_count_next = length_count + 8'd1;
            else len_sat_next = 1'b1;
          end
        end
        default: rescan = 1'b1;
      endcase
    end else begin
      rescan = 1'b1;
    end

    // fresh scan of the byte from idle
    if (!in_mode && rescan) begin
      scan_state_next = ST_IDLE;
      if (!is_space(c)) begin
        if (c == "/" || is_alpha(c) || is_digit(c) || c == "'" || c == "\"" ||
            c == "=" || c == "!" || c == "<" || c == ">" || c == "&" || c == "|") begin
          start_line_next        = current_line;
          start_column_next      = current_column;
          start_position_next    = current_offset;
          length_count_next      = 8'd1;
          len_sat_next           = 1'b0;
          val_sat_next           = 1'b0;
          value_accumulator_next = '0;
          escape_pending_next    = 1'b0;
          if (c == "/") scan_state_next = ST_SLASH;
          else if (is_alpha(c)) begin
            scan_state_next     = ST_IDENT;
            keyword_window_next = 64'(c);
          end else if (is_digit(c)) begin
            scan_state_next        = ST_NUM;
            value_accumulator_next = dval;
          end else if (c == "'") scan_state_next = ST_CHAR;
          else if (c == "\"") scan_state_next = ST_STR;
          else begin
            scan_state_next   = ST_OP;
            pending_char_next = c;
          end
        end else begin
          t = op1_type(c);
          if (t == 6'd0) t = delim_type(c);
          if (t != 6'd0) begin
            tk[n] = '{t, current_line, current_column, 32'(current_offset), 8'd1, 64'd0, 1'b0};
            n = n + 2'd1;
          end
        end
      end
    end

    // end of source appends EOF
    if (in_mode) begin
      tk[n] = '{T_EOF, current_line, current_column, 32'(current_offset), 8'd0, 64'd0, 1'b0};
      n = n + 2'd1;
    end

    g.count = n;
    g.t0 = tk[0];
    g.t1 = tk[1];
    g.t2 = tk[2];
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst || (fire && in_mode)) begin
      scan_state        <= ST_IDLE;
      pending_char      <= '0;
      keyword_window    <= '0;
      current_line      <= LC_BITS'(1);
      current_column    <= LC_BITS'(1);
      current_offset    <= '0;
      start_line        <= LC_BITS'(1);
      start_column      <= LC_BITS'(1);
      start_position    <= '0;
      length_count      <= '0;
      value_accumulator <= '0;
      escape_pending    <= 1'b0;
      len_sat           <= 1'b0;
      val_sat           <= 1'b0;
      mark_line         <= '0;
      mark_column       <= '0;
      mark_offset       <= '0;
    end else if (fire) begin
      scan_state        <= scan_state_next;
      pending_char      <= pending_char_next;
      keyword_window    <= keyword_window_next;
      start_line        <= start_line_next;
      start_column      <= start_column_next;
      start_position    <= start_position_next;
      length_count      <= length_count_next;
      value_accumulator <= value_accumulator_next;
      escape_pending    <= escape_pending_next;
      len_sat           <= len_sat_next;
      val_sat           <= val_sat_next;
      mark_line         <= mark_line_next;
      mark_column       <= mark_column_next;
      mark_offset       <= mark_offset_next;
      if (in_byte == "\n") begin
        if (current_line < LCMAX) current_line <= current_line + LC_BITS'(1);
        current_column <= LC_BITS'(1);
      end else if (current_column < LCMAX) begin
        current_column <= current_column + LC_BITS'(1);
      end
      current_offset <= current_offset + POSITION_BITS'(1);
    end
  end

  // output stage toward the queue; empty groups are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
    end else if (in_ready) begin
      grp_valid <= fire && (g.count != 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) grp <= g;
  end

endmodule

// ----- sv/csl_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_back: token queue and serializer
// Holds token groups in a small queue and sends their tokens one per cycle while
// out_ready is high, marking the final token of each group.
// ----------------------------------------------------------------------------
module csl_back import csl_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         grp_valid,
  output logic         grp_ready,
  input  group_t       grp,
  output logic         out_valid,
  input  logic         out_ready,
  output token_t       out_token,
  output logic         out_last
);

  localparam int DEPTH = 4;

  group_t     q [DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] fill;
  logic [1:0] sel;
  group_t     head;
  logic       push, pop, take;

  assign head      = q[rd_ptr];
  assign grp_ready = (fill != 3'(DEPTH));
  assign push      = grp_valid && grp_ready;
  assign out_valid = (fill != 3'd0);
  assign take      = out_valid && out_ready;
  assign out_last  = (sel == head.count - 2'd1);
  assign pop       = take && out_last;

  always_comb begin
    case (sel)
      2'd0: out_token = head.t0;
      2'd1: out_token = head.t1;
      default: out_token = head.t2;
    endcase
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= grp;
  end

  // queue pointers and token select
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      sel    <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + 3'(push) - 3'(pop);
      if (pop) sel <= '0;
      else if (take) sel <= sel + 2'd1;
    end
  end

endmodule
